>>> src/tdt_pkg.sv
// Shared types and constants for the tile dirty tracker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tdt_pkg;

	localparam int MAX_COLS = 8;
	localparam int MAX_ROWS = 8;
	localparam int NTILES   = MAX_COLS * MAX_ROWS;
	localparam int SWEEP    = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int CNT_W    = $clog2(SWEEP + 1);
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IDX_W    = (NTILES > 1) ? $clog2(NTILES) : 1;
	localparam int DIM_W    = 13;
	localparam int CRD_W    = 12;
	localparam int ACC_W    = DIM_W + CNT_W;

	typedef enum logic [2:0] {
		FUNC_SET        = 3'd0,
		FUNC_INFO_TILE  = 3'd1,
		FUNC_INFO_PIX   = 3'd2,
		FUNC_ALL_DIRTY  = 3'd3,
		FUNC_ALL_CLEAN  = 3'd4,
		FUNC_LIST_DIRTY = 3'd5,
		FUNC_LIST_RECT  = 3'd6,
		FUNC_NOP        = 3'd7
	} func_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_EDGE   = 2'd2;
	localparam logic [1:0] REG_SPARE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DISPATCH,
		ST_WALK,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic set_one;
		logic set_all;
		logic all_value;
		logic single_init;
		logic walk_init;
		logic walk_step;
		logic final_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  sweep_last;
		logic  walk_empty;
		logic  step_ok;
		logic  walk_end;
		logic  out_free;
	} sts_t;

endpackage

>>> src/tile_dirty_tracker_unit.sv
// Top level of the tile dirty tracker: controller plus datapath.
// Depends on tdt_pkg, tdt_ctrl and tdt_datapath.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   input    | in_valid / in_ready     | func, tile_col, tile_row, dirty_value,
//            |                         | pix_x, pix_y, rect_w, rect_h
//   output   | out_valid / out_ready   | out_col, out_row, origin_x, origin_y,
//            |                         | span_w, span_h, tile_ok, tile_dirty, last
//   config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// Each transaction is accepted in the idle state, then runs a sweep of the shared
// edge accumulator (tile counts and quotients) and a dispatch state.
// Listings then visit one tile per cycle unless the walk is held, up to 64, then a final state.
// Output stalls hold the walk only when a finished result cannot be handed over.
// Reset sets every dirty bit, clears the raster size and sets the edge to 256.
`timescale 1ns / 1ps

module tile_dirty_tracker_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [tdt_pkg::DIM_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            func,
	input  logic [tdt_pkg::CRD_W-1:0] tile_col,
	input  logic [tdt_pkg::CRD_W-1:0] tile_row,
	input  logic                  dirty_value,
	input  logic [tdt_pkg::CRD_W-1:0] pix_x,
	input  logic [tdt_pkg::CRD_W-1:0] pix_y,
	input  logic [tdt_pkg::CRD_W-1:0] rect_w,
	input  logic [tdt_pkg::CRD_W-1:0] rect_h,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [tdt_pkg::CRD_W-1:0] out_col,
	output logic [tdt_pkg::CRD_W-1:0] out_row,
	output logic [tdt_pkg::CRD_W-1:0] origin_x,
	output logic [tdt_pkg::CRD_W-1:0] origin_y,
	output logic [tdt_pkg::DIM_W-1:0] span_w,
	output logic [tdt_pkg::DIM_W-1:0] span_h,
	output logic                  tile_ok,
	output logic                  tile_dirty,
	output logic                  last
);
	import tdt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.dirty_value (dirty_value),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.rect_w      (rect_w),
		.rect_h      (rect_h),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_col     (out_col),
		.out_row     (out_row),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.span_w      (span_w),
		.span_h      (span_h),
		.tile_ok     (tile_ok),
		.tile_dirty  (tile_dirty),
		.last        (last)
	);

endmodule

>>> src/tdt_ctrl.sv
// Controller state machine of the tile dirty tracker.
// Depends on tdt_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module tdt_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tdt_pkg::sts_t sts,
	output tdt_pkg::cmd_t cmd
);
	import tdt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (sts.func)
					FUNC_SET: begin
						cmd.set_one = 1'b1;
						state_d     = ST_IDLE;
					end
					FUNC_INFO_TILE, FUNC_INFO_PIX: begin
						cmd.single_init = 1'b1;
						state_d         = ST_FINAL;
					end
					FUNC_ALL_DIRTY: begin
						cmd.set_all   = 1'b1;
						cmd.all_value = 1'b1;
						state_d       = ST_IDLE;
					end
					FUNC_ALL_CLEAN: begin
						cmd.set_all = 1'b1;
						state_d     = ST_IDLE;
					end
					FUNC_LIST_DIRTY, FUNC_LIST_RECT: begin
						cmd.walk_init = 1'b1;
						state_d       = sts.walk_empty ? ST_FINAL : ST_WALK;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.step_ok && sts.walk_end) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.final_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/tdt_datapath.sv
// Datapath of the tile dirty tracker: configuration, dirty bits, divide sweep,
// tile walk and the output register. Depends on tdt_pkg.
`timescale 1ns / 1ps

module tdt_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [tdt_pkg::DIM_W-1:0] cfg_data,
	input  logic [2:0]            func,
	input  logic [tdt_pkg::CRD_W-1:0] tile_col,
	input  logic [tdt_pkg::CRD_W-1:0] tile_row,
	input  logic                  dirty_value,
	input  logic [tdt_pkg::CRD_W-1:0] pix_x,
	input  logic [tdt_pkg::CRD_W-1:0] pix_y,
	input  logic [tdt_pkg::CRD_W-1:0] rect_w,
	input  logic [tdt_pkg::CRD_W-1:0] rect_h,
	input  tdt_pkg::cmd_t         cmd,
	output tdt_pkg::sts_t         sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [tdt_pkg::CRD_W-1:0] out_col,
	output logic [tdt_pkg::CRD_W-1:0] out_row,
	output logic [tdt_pkg::CRD_W-1:0] origin_x,
	output logic [tdt_pkg::CRD_W-1:0] origin_y,
	output logic [tdt_pkg::DIM_W-1:0] span_w,
	output logic [tdt_pkg::DIM_W-1:0] span_h,
	output logic                  tile_ok,
	output logic                  tile_dirty,
	output logic                  last
);
	import tdt_pkg::*;

	// Configuration and tile state.
	logic [DIM_W-1:0]  width_q, height_q, edge_q;
	logic [NTILES-1:0] dirty_q;

	// Latched input transaction.
	func_t             func_q;
	logic [CRD_W-1:0]  tcol_q, trow_q, px_q, py_q, rw_q, rh_q;
	logic              dv_q;

	// Sweep: k*edge accumulated one step a cycle gives tile counts and
	// saturated quotients without a divider.
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  step_q, cols_q, rows_q, qx_q, qy_q, qex_q, qey_q;

	// Walk and pending result.
	logic [CNT_W-1:0]  c_q, r_q, c_lo_q, c_hi_q, r_hi_q;
	logic [CRD_W-1:0]  pend_c_q, pend_r_q;
	logic              pend_q;

	logic              out_valid_q;
	logic [CRD_W-1:0]  out_col_q, out_row_q, origin_x_q, origin_y_q;
	logic [DIM_W-1:0]  span_w_q, span_h_q;
	logic              tile_ok_q, tile_dirty_q, last_q;

	logic              grid_ok;
	logic [CNT_W-1:0]  cols_eff, rows_eff, ex_eff, ey_eff;
	logic [ACC_W-1:0]  acc_next;
	logic [DIM_W-1:0]  sum_x, sum_y;
	logic              out_free, qualify, step_ok, walk_end, walk_empty;
	logic [IDX_W-1:0]  walk_idx, set_idx, pend_idx;
	logic              set_inside, pend_inside;
	logic [ACC_W-1:0]  ox, oy, sw_full, sh_full;
	logic              emit_load, emit_last;

	assign grid_ok  = (width_q != '0) && (height_q != '0) && (edge_q != '0);
	assign cols_eff = grid_ok ? cols_q : '0;
	assign rows_eff = grid_ok ? rows_q : '0;
	assign ex_eff   = (qex_q > cols_eff - 1'b1) ? cols_eff - 1'b1 : qex_q;
	assign ey_eff   = (qey_q > rows_eff - 1'b1) ? rows_eff - 1'b1 : qey_q;
	assign acc_next = acc_q + ACC_W'(edge_q);
	assign sum_x    = DIM_W'(px_q) + DIM_W'(rw_q);
	assign sum_y    = DIM_W'(py_q) + DIM_W'(rh_q);
	assign out_free = !out_valid_q || out_ready;

	assign walk_empty = (cols_eff == '0) || (rows_eff == '0) ||
		((func_q == FUNC_LIST_RECT) && ((qx_q > ex_eff) || (qy_q > ey_eff)));

	assign walk_idx = IDX_W'(int'(r_q) * MAX_COLS + int'(c_q));
	assign qualify  = (func_q == FUNC_LIST_DIRTY) ? dirty_q[walk_idx] : 1'b1;
	assign step_ok  = !(qualify && pend_q && !out_free);
	assign walk_end = (c_q == c_hi_q) && (r_q == r_hi_q);

	assign set_inside = (tcol_q < CRD_W'(cols_eff)) && (trow_q < CRD_W'(rows_eff));
	assign set_idx    = IDX_W'(int'(trow_q[ROW_W-1:0]) * MAX_COLS + int'(tcol_q[COL_W-1:0]));

	// Geometry of the pending tile; only meaningful when it lies in the grid.
	assign pend_inside = pend_q && (pend_c_q < CRD_W'(cols_eff)) &&
		(pend_r_q < CRD_W'(rows_eff));
	assign pend_idx = IDX_W'(int'(pend_r_q[ROW_W-1:0]) * MAX_COLS +
		int'(pend_c_q[COL_W-1:0]));
	assign ox       = ACC_W'(pend_c_q[COL_W-1:0]) * ACC_W'(edge_q);
	assign oy       = ACC_W'(pend_r_q[ROW_W-1:0]) * ACC_W'(edge_q);
	assign sw_full  = ACC_W'(width_q) - ox;
	assign sh_full  = ACC_W'(height_q) - oy;

	assign emit_load = cmd.final_load || (cmd.walk_step && step_ok && qualify && pend_q);
	assign emit_last = cmd.final_load;

	always_comb begin
		sts            = '0;
		sts.func       = func_q;
		sts.sweep_last = (step_q == CNT_W'(SWEEP - 1));
		sts.walk_empty = walk_empty;
		sts.step_ok    = step_ok;
		sts.walk_end   = walk_end;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			edge_q   <= DIM_W'(256);
			dirty_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_EDGE:   edge_q   <= cfg_data;
				default:    ;
			endcase
			if (cfg_index != REG_SPARE) dirty_q <= '1;
		end else if (cmd.set_all) begin
			dirty_q <= {NTILES{cmd.all_value}};
		end else if (cmd.set_one && set_inside) begin
			dirty_q[set_idx] <= dv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			tcol_q <= tile_col;
			trow_q <= tile_row;
			dv_q   <= dirty_value;
			px_q   <= pix_x;
			py_q   <= pix_y;
			rw_q   <= rect_w;
			rh_q   <= rect_h;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q  <= '0;
			step_q <= '0;
			cols_q <= '0;
			rows_q <= '0;
			qx_q   <= '0;
			qy_q   <= '0;
			qex_q  <= '0;
			qey_q  <= '0;
		end else if (cmd.sweep) begin
			// Step k compares (k-1)*edge for the counts and k*edge for quotients.
			acc_q  <= acc_next;
			step_q <= step_q + 1'b1;
			if (step_q < CNT_W'(MAX_COLS) && acc_q < ACC_W'(width_q))  cols_q <= cols_q + 1'b1;
			if (step_q < CNT_W'(MAX_ROWS) && acc_q < ACC_W'(height_q)) rows_q <= rows_q + 1'b1;
			if (acc_next <= ACC_W'(px_q))  qx_q  <= qx_q + 1'b1;
			if (acc_next <= ACC_W'(py_q))  qy_q  <= qy_q + 1'b1;
			if (acc_next <= ACC_W'(sum_x)) qex_q <= qex_q + 1'b1;
			if (acc_next <= ACC_W'(sum_y)) qey_q <= qey_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			if (func_q == FUNC_LIST_RECT) begin
				c_q    <= qx_q;
				r_q    <= qy_q;
				c_lo_q <= qx_q;
				c_hi_q <= ex_eff;
				r_hi_q <= ey_eff;
			end else begin
				c_q    <= '0;
				r_q    <= '0;
				c_lo_q <= '0;
				c_hi_q <= cols_eff - 1'b1;
				r_hi_q <= rows_eff - 1'b1;
			end
		end else if (cmd.walk_step && step_ok) begin
			if (c_q == c_hi_q) begin
				c_q <= c_lo_q;
				r_q <= r_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.walk_init) begin
			pend_q <= 1'b0;
		end else if (cmd.single_init || (cmd.walk_step && step_ok && qualify)) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single_init) begin
			if (func_q == FUNC_INFO_TILE) begin
				pend_c_q <= tcol_q;
				pend_r_q <= trow_q;
			end else begin
				pend_c_q <= CRD_W'(qx_q);
				pend_r_q <= CRD_W'(qy_q);
			end
		end else if (cmd.walk_step && step_ok && qualify) begin
			pend_c_q <= CRD_W'(c_q);
			pend_r_q <= CRD_W'(r_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			last_q <= emit_last;
			if (pend_inside) begin
				out_col_q    <= pend_c_q;
				out_row_q    <= pend_r_q;
				origin_x_q   <= ox[CRD_W-1:0];
				origin_y_q   <= oy[CRD_W-1:0];
				span_w_q     <= (sw_full > ACC_W'(edge_q)) ? edge_q : sw_full[DIM_W-1:0];
				span_h_q     <= (sh_full > ACC_W'(edge_q)) ? edge_q : sh_full[DIM_W-1:0];
				tile_ok_q    <= 1'b1;
				tile_dirty_q <= dirty_q[pend_idx];
			end else begin
				out_col_q    <= '0;
				out_row_q    <= '0;
				origin_x_q   <= '0;
				origin_y_q   <= '0;
				span_w_q     <= '0;
				span_h_q     <= '0;
				tile_ok_q    <= 1'b0;
				tile_dirty_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign origin_x   = origin_x_q;
	assign origin_y   = origin_y_q;
	assign span_w     = span_w_q;
	assign span_h     = span_h_q;
	assign tile_ok    = tile_ok_q;
	assign tile_dirty = tile_dirty_q;
	assign last       = last_q;

endmodule
